// File: sv/lfu_pkg.sv
package lfu_pkg;

    localparam int unsigned ENTRIES_DEF    = 16;
    localparam int unsigned KEY_BITS_DEF   = 16;
    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned VALUE_BITS     = 31;
    localparam int unsigned CAP_BITS       = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_DONE
    } t_state;

endpackage

// File: sv/lfu_scan_unit.sv
module lfu_scan_unit #(
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter int unsigned RANK_BITS  = 4
) (
    input  logic                  i_cand_valid,
    input  logic [COUNT_BITS-1:0] i_cand_count,
    input  logic [RANK_BITS-1:0]  i_cand_rank,
    input  logic                  i_best_found,
    input  logic [COUNT_BITS-1:0] i_best_count,
    input  logic [RANK_BITS-1:0]  i_best_rank,
    output logic                  o_better
);

    // The candidate wins on a lower count, or an equal count and an older rank.
    assign o_better = i_cand_valid && (!i_best_found || (i_cand_count < i_best_count) ||
                      ((i_cand_count == i_best_count) && (i_cand_rank > i_best_rank)));

endmodule

// File: sv/lfu_cache_store.sv
// Least-frequently-used key-value store with least-recently-used tie-break.
// Every request walks the entries twice, one entry a cycle; the scan pass goes through
// one compare unit. A scan pass finds the key, the eviction victim and a free slot.
// After a decide state, an aging pass updates the ranks and writes any new entry. The
// block takes no new request while one is at work or while a result waits in its
// output register. The next request can be taken in the cycle after the result
// leaves. Capacity above ENTRIES acts as ENTRIES.
module lfu_cache_store #(
    parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int unsigned KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
    parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfu_pkg::CAP_BITS-1:0]  i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [lfu_pkg::VALUE_BITS-1:0] i_write_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [lfu_pkg::VALUE_BITS-1:0] o_read_value,
    output logic                          o_evicted,
    output logic [KEY_BITS-1:0]           o_evicted_key
);

    localparam int unsigned IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned RANK_BITS = IDX_BITS;
    localparam int unsigned OCC_BITS  = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    lfu_pkg::t_state r_state, n_state;

    logic                  r_valid [ENTRIES];
    logic [KEY_BITS-1:0]   r_ekey  [ENTRIES];
    logic [lfu_pkg::VALUE_BITS-1:0] r_evalue [ENTRIES];
    logic [COUNT_BITS-1:0] r_ecount [ENTRIES];
    logic [RANK_BITS-1:0]  r_erank  [ENTRIES];
    logic [OCC_BITS-1:0]   r_occ;
    logic [lfu_pkg::CAP_BITS-1:0] r_cap;

    logic r_put;
    logic [KEY_BITS-1:0] r_key;
    logic [lfu_pkg::VALUE_BITS-1:0] r_wval;
    logic [IDX_BITS-1:0] r_idx;
    logic r_found;
    logic [IDX_BITS-1:0] r_slot;
    logic r_bfound;
    logic [IDX_BITS-1:0] r_best;
    logic r_ffound;
    logic [IDX_BITS-1:0] r_free;
    logic r_evict;
    logic [RANK_BITS-1:0] r_ref_rank;
    logic r_ins;
    logic [IDX_BITS-1:0] r_ins_slot;

    logic r_ovalid;
    logic r_ohit;
    logic [lfu_pkg::VALUE_BITS-1:0] r_oval;
    logic r_oev;
    logic [KEY_BITS-1:0] r_oekey;

    logic better;
    logic accept;
    logic last;
    logic [OCC_BITS-1:0] cap_eff;
    logic put_miss;
    logic do_evict;
    logic [IDX_BITS-1:0] ins_slot;
    logic ins_ok;

    assign accept = i_valid && !o_stall;
    assign last = (r_idx == LAST_IDX);
    assign cap_eff = (32'(r_cap) > ENTRIES) ? OCC_BITS'(ENTRIES) : OCC_BITS'(r_cap);
    assign put_miss = !r_found && r_put && (cap_eff != '0);
    assign do_evict = put_miss && (r_occ >= cap_eff) && (r_occ != '0);
    assign ins_slot = do_evict ? r_best : r_free;
    assign ins_ok = put_miss && (do_evict || r_ffound);

    lfu_scan_unit #(.COUNT_BITS(COUNT_BITS), .RANK_BITS(RANK_BITS)) u_scan (
        .i_cand_valid(r_valid[r_idx]),
        .i_cand_count(r_ecount[r_idx]),
        .i_cand_rank(r_erank[r_idx]),
        .i_best_found(r_bfound),
        .i_best_count(r_ecount[r_best]),
        .i_best_rank(r_erank[r_best]),
        .o_better(better)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::ST_IDLE:   if (accept) n_state = lfu_pkg::ST_SCAN;
            lfu_pkg::ST_SCAN:   if (last) n_state = lfu_pkg::ST_DECIDE;
            lfu_pkg::ST_DECIDE: n_state = lfu_pkg::ST_AGE;
            lfu_pkg::ST_AGE:    if (last) n_state = lfu_pkg::ST_DONE;
            lfu_pkg::ST_DONE:   if (!r_ovalid || !i_stall) n_state = lfu_pkg::ST_IDLE;
            default:            n_state = lfu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != lfu_pkg::ST_IDLE) || r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
            r_occ <= '0;
            r_cap <= lfu_pkg::CAP_RESET;
            r_ovalid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) r_valid[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (r_state == lfu_pkg::ST_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                lfu_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_put <= i_req_type;
                        r_key <= i_key;
                        r_wval <= i_write_value;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_bfound <= 1'b0;
                        r_ffound <= 1'b0;
                        r_best <= '0;
                    end
                end
                lfu_pkg::ST_SCAN: begin
                    if (r_valid[r_idx] && r_ekey[r_idx] == r_key && !r_found) begin
                        r_found <= 1'b1;
                        r_slot <= r_idx;
                    end
                    if (better) begin
                        r_bfound <= 1'b1;
                        r_best <= r_idx;
                    end
                    if (!r_valid[r_idx] && !r_ffound) begin
                        r_ffound <= 1'b1;
                        r_free <= r_idx;
                    end
                    r_idx <= last ? '0 : r_idx + 1'b1;
                end
                lfu_pkg::ST_DECIDE: begin
                    r_ohit <= r_found;
                    r_oval <= (r_found && r_put == lfu_pkg::REQ_GET) ? r_evalue[r_slot] : '0;
                    r_oev <= do_evict;
                    r_oekey <= do_evict ? r_ekey[r_best] : '0;
                    r_evict <= do_evict;
                    r_ins <= ins_ok;
                    r_ins_slot <= ins_slot;
                    r_ref_rank <= r_found ? r_erank[r_slot] : r_erank[r_best];
                    if (r_found) begin
                        if (r_put == lfu_pkg::REQ_PUT) r_evalue[r_slot] <= r_wval;
                        if (r_ecount[r_slot] != COUNT_MAX)
                            r_ecount[r_slot] <= r_ecount[r_slot] + 1'b1;
                    end
                    if (do_evict) r_valid[r_best] <= 1'b0;
                end
                lfu_pkg::ST_AGE: begin
                    if (r_idx == r_slot && r_found) begin
                        r_erank[r_idx] <= '0;
                    end else if (r_ins && r_idx == r_ins_slot) begin
                        r_valid[r_idx] <= 1'b1;
                        r_ekey[r_idx] <= r_key;
                        r_evalue[r_idx] <= r_wval;
                        r_ecount[r_idx] <= COUNT_BITS'(1);
                        r_erank[r_idx] <= '0;
                    end else if (r_valid[r_idx]) begin
                        if (r_found) begin
                            if (r_erank[r_idx] < r_ref_rank)
                                r_erank[r_idx] <= r_erank[r_idx] + 1'b1;
                        end else if (r_ins) begin
                            if (!(r_evict && r_erank[r_idx] > r_ref_rank))
                                r_erank[r_idx] <= r_erank[r_idx] + 1'b1;
                        end
                    end
                    if (last && r_ins && !r_evict) r_occ <= r_occ + 1'b1;
                    r_idx <= last ? '0 : r_idx + 1'b1;
                end
                lfu_pkg::ST_DONE: ;
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_hit = r_ohit;
    assign o_read_value = r_oval;
    assign o_evicted = r_oev;
    assign o_evicted_key = r_oekey;

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfu_pkg::ST_SCAN) |-> o_stall)
        else $error("scan not stalled");
    a_occ_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= ENTRIES)
        else $error("occupancy overflow");
    a_ev_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> !o_hit)
        else $error("eviction on hit");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == lfu_pkg::ST_DONE)
        else $error("result outside done");

endmodule
